FILE: hdl/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions of the SHA-256 stream hasher.
// Used by sha256_round and sha256_stream_hash. No dependencies.
package sha256_pkg;

    typedef logic [31:0] t_word;

    // Working variables or hash words, index 0 is a / H0.
    typedef logic [0:7][31:0] t_vars;

    // Schedule window taps that the round unit needs.
    typedef struct packed {
        t_word w0;
        t_word w1;
        t_word w9;
        t_word w14;
    } t_taps;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_FINAL,
        S_OUT
    } t_state;

    localparam t_vars HASH_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

FILE: hdl/sha256_stream_hash.sv
// sha256_stream_hash: SHA-256 over a byte stream, one round per clock on a shared round unit.
// Depends on sha256_pkg and sha256_round.
//
// Each input beat carries at most one message byte (tuser = byte valid) and may close the
// message (tlast). The 64th byte of a block starts the compression, which holds s_axis_tready
// low through the 64 rounds on the single round unit and the fold of the working variables
// into the hash, so no byte is taken while a block is compressed. At end of message the
// padding is written one byte a cycle from the fill position to the end of the block, then
// compressed; when fewer than nine bytes remain a second padding block is written and
// compressed the same way. The digest then leaves as eight beats, H0 first, tuser the word
// index and tlast on the eighth; the next message starts once the eighth beat is taken. The
// byte count wraps modulo 2^64. Bytes are packed straight into the 16-word schedule window,
// which shifts during the rounds, so no separate block buffer exists.
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha256_pkg::t_state r_state;
    sha256_pkg::t_state n_state;

    logic [63:0]       r_byte_cnt;
    sha256_pkg::t_vars r_h;
    sha256_pkg::t_vars r_v;
    logic [31:0]       r_w [16];     // schedule window, also the block buffer
    logic [5:0]        r_round;
    logic [5:0]        r_pos;        // padding write position
    logic              r_mark;       // 0x80 already written
    logic              r_len_ph;     // this padding block carries the length
    logic              r_in_pad;     // current compression is a padding block
    logic              r_eom_pend;   // message ended (tlast taken); read only after a full block
    logic [2:0]        r_out_idx;

    logic              in_acc;
    logic              out_acc;
    logic [5:0]        cur_pos;
    logic [5:0]        eom_pos;
    logic              wr_en;
    logic [5:0]        wr_pos;
    logic [7:0]        wr_byte;
    logic [63:0]       bit_len;
    logic [7:0]        len_byte;
    logic [7:0]        pad_byte;
    sha256_pkg::t_taps taps;
    sha256_pkg::t_vars round_vars;
    logic [31:0]       w_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cur_pos = r_byte_cnt[5:0];
    // first pad position when the message ends in the idle state
    assign eom_pos = s_axis_tuser ? cur_pos + 6'd1 : cur_pos;

    // ---- round unit ----
    assign taps = '{w0: r_w[0], w1: r_w[1], w9: r_w[9], w14: r_w[14]};

    sha256_round u_round (
        .i_vars   (r_v),
        .i_k      (sha256_pkg::K_ROUND[r_round]),
        .i_taps   (taps),
        .o_vars   (round_vars),
        .o_w_next (w_next)
    );

    // ---- padding byte ----
    assign bit_len  = {r_byte_cnt[60:0], 3'b000};
    assign len_byte = bit_len[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        if (!r_mark) begin
            pad_byte = sha256_pkg::PAD_MARK;
        end else if (r_len_ph && (r_pos >= sha256_pkg::LEN_POS)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        wr_en   = (r_state == sha256_pkg::S_PAD)
               || ((r_state == sha256_pkg::S_IDLE) && in_acc && s_axis_tuser);
        wr_pos  = (r_state == sha256_pkg::S_PAD) ? r_pos : cur_pos;
        wr_byte = (r_state == sha256_pkg::S_PAD) ? pad_byte : s_axis_tdata;
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser && (cur_pos == 6'd63)) begin
                        n_state = sha256_pkg::S_COMP;
                    end else if (s_axis_tlast) begin
                        n_state = sha256_pkg::S_PAD;
                    end
                end
            end
            sha256_pkg::S_PAD: begin
                if (r_pos == 6'd63) begin
                    n_state = sha256_pkg::S_COMP;
                end
            end
            sha256_pkg::S_COMP: begin
                if (r_round == 6'd63) begin
                    n_state = sha256_pkg::S_FINAL;
                end
            end
            sha256_pkg::S_FINAL: begin
                if (r_in_pad && r_len_ph) begin
                    n_state = sha256_pkg::S_OUT;
                end else if (r_in_pad || r_eom_pend) begin
                    n_state = sha256_pkg::S_PAD;
                end else begin
                    n_state = sha256_pkg::S_IDLE;
                end
            end
            sha256_pkg::S_OUT: begin
                if (out_acc && (r_out_idx == 3'd7)) begin
                    n_state = sha256_pkg::S_IDLE;
                end
            end
            default: n_state = sha256_pkg::S_IDLE;
        endcase
    end

    // ---- port outputs ----
    always_comb begin
        s_axis_tready = (r_state == sha256_pkg::S_IDLE);
        m_axis_tvalid = (r_state == sha256_pkg::S_OUT);
        m_axis_tdata  = r_h[r_out_idx];
        m_axis_tuser  = r_out_idx;
        m_axis_tlast  = (r_out_idx == 3'd7);
    end

    // ---- control and hash state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::S_IDLE;
            r_byte_cnt <= 64'd0;
            r_h        <= sha256_pkg::HASH_INIT;
            r_round    <= 6'd0;
            r_pos      <= 6'd0;
            r_mark     <= 1'b0;
            r_len_ph   <= 1'b0;
            r_in_pad   <= 1'b0;
            r_eom_pend <= 1'b0;
            r_out_idx  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_round <= (r_state == sha256_pkg::S_COMP) ? r_round + 6'd1 : 6'd0;

            unique case (r_state)
                sha256_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser) begin
                            r_byte_cnt <= r_byte_cnt + 64'd1;
                        end
                        r_in_pad   <= 1'b0;
                        r_eom_pend <= s_axis_tlast;
                        r_pos      <= eom_pos;
                        r_mark     <= 1'b0;
                        r_len_ph   <= (eom_pos < sha256_pkg::LEN_POS);
                    end
                end
                sha256_pkg::S_PAD: begin
                    r_pos    <= r_pos + 6'd1;
                    r_mark   <= 1'b1;
                    r_in_pad <= 1'b1;
                end
                sha256_pkg::S_COMP: begin
                end
                sha256_pkg::S_FINAL: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    // second padding block, or padding after a full last block
                    r_pos    <= 6'd0;
                    r_mark   <= r_in_pad;
                    r_len_ph <= 1'b1;
                end
                sha256_pkg::S_OUT: begin
                    if (out_acc) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_h        <= sha256_pkg::HASH_INIT;
                            r_byte_cnt <= 64'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---- datapath: window and working variables ----
    always_ff @(posedge i_clk) begin
        if (r_state == sha256_pkg::S_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_next;
        end else if (wr_en) begin
            r_w[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end

        if (r_state == sha256_pkg::S_COMP) begin
            r_v <= round_vars;
        end else if (n_state == sha256_pkg::S_COMP) begin
            r_v <= r_h;
        end
    end

    // ---- assertions ----
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while digest is being sent");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == sha256_pkg::S_COMP) |-> (r_round == 6'd0))
        else $error("compression started with non-zero round count");

    a_pad_to_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sha256_pkg::S_PAD) && (r_pos == 6'd63))
        |=> ((r_state == sha256_pkg::S_COMP) && r_in_pad))
        else $error("padding block not handed to compression");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast)
        |=> ((r_byte_cnt == 64'd0) && (r_state == sha256_pkg::S_IDLE)))
        else $error("hash state not restarted after last digest beat");

endmodule

FILE: hdl/sha256_round.sv
// sha256_round: one SHA-256 compression round plus the next schedule word.
// Depends on sha256_pkg.
module sha256_round (
    input  sha256_pkg::t_vars i_vars,
    input  logic [31:0]       i_k,
    input  sha256_pkg::t_taps i_taps,
    output sha256_pkg::t_vars o_vars,
    output logic [31:0]       o_w_next
);

    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        t1 = i_vars[7] + sha256_pkg::big_sigma1(i_vars[4])
           + sha256_pkg::choose(i_vars[4], i_vars[5], i_vars[6]) + i_k + i_taps.w0;
        t2 = sha256_pkg::big_sigma0(i_vars[0])
           + sha256_pkg::majority(i_vars[0], i_vars[1], i_vars[2]);
        o_vars = '{t1 + t2, i_vars[0], i_vars[1], i_vars[2],
                   i_vars[3] + t1, i_vars[4], i_vars[5], i_vars[6]};
        // w[t+16] from the window taps
        o_w_next = sha256_pkg::small_sigma1(i_taps.w14) + i_taps.w9
                 + sha256_pkg::small_sigma0(i_taps.w1) + i_taps.w0;
    end

endmodule
